### rtl/rc4sc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4sc_pkg
// Shared types and codes for the RC4 stream cipher block.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

	localparam int unsigned SBOX_DEPTH = 256;
	localparam int unsigned SBOX_AW    = 8;
	localparam logic [8:0]  KEY_LENGTH_RESET = 9'd16;

	// request commands
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_SCHED = 2'd1;
	localparam logic [1:0] CMD_CRYPT = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_KEY   = 2'd0;
	localparam logic [1:0] KIND_SCHED = 2'd1;
	localparam logic [1:0] KIND_CRYPT = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] key_index;
		logic [7:0] key_byte;
		logic [7:0] data_byte;
		logic       last_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic       out_last;
	} rsp_t;

	// access to the permutation memory: one write and one read per cycle
	typedef struct packed {
		logic               we;
		logic [SBOX_AW-1:0] waddr;
		logic [7:0]         wdata;
		logic [SBOX_AW-1:0] raddr;
	} sbox_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_KS_A,
		ST_KS_B,
		ST_KS_C,
		ST_CR_A,
		ST_CR_B,
		ST_CR_C,
		ST_PUSH
	} state_t;

endpackage

### rtl/rc4sc_sbox_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4sc_sbox_ram
// 256 x 8 permutation memory, one write and one registered read per cycle.
// A read of the entry written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module rc4sc_sbox_ram (
	input  logic                  clk,
	input  rc4sc_pkg::sbox_req_t  req,
	output logic [7:0]            rdata
);

	logic [7:0] mem [rc4sc_pkg::SBOX_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[req.raddr];
	end

endmodule

### rtl/rc4_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 key load, key schedule and keystream crypt over one permutation memory.
// ----------------------------------------------------------------------------
//   channel  signals                      direction  payload
//   request  in_valid, in_ready, in_req   in         req_t
//   result   out_valid, out_ready, out_rsp out       rsp_t
//   config   cfg_valid, cfg_ready, cfg_data in       key_length, 9 bits
//
// Load completes on accept; crypt is the accept plus three memory steps (read
// i, read j, swap write with keystream read); schedule makes 256 identity
// writes, then three steps per entry on the single read port. One request is
// in work at a time; a new one is taken while a result waits in the output
// register. A result that finds the output register full is held until it
// drains. Reset clears the indices, not memory, and sets key length to 16.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
	parameter int unsigned MAX_KEY_BYTES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rc4sc_pkg::req_t  in_req,
	output logic             out_valid,
	input  logic             out_ready,
	output rc4sc_pkg::rsp_t  out_rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [8:0]       cfg_data
);

	localparam int unsigned KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

	rc4sc_pkg::state_t    state_q, state_d;
	rc4sc_pkg::sbox_req_t sbox_req;
	rc4sc_pkg::rsp_t      res, res_q, out_q;
	logic                 res_valid;
	logic                 out_valid_q;
	logic                 slot_free;
	logic [7:0]           s_rdata;

	logic [8:0]    key_length_q;
	logic [8:0]    n_eff;
	logic [7:0]    key_mem [MAX_KEY_BYTES];
	logic [7:0]    key_rd_q;
	logic [KW-1:0] kk_q;
	logic          kk_last;

	logic [7:0] i_q, j_q, k_q, m_q, a_q, b_q, t_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       fwd_q;
	logic [7:0] ks_a, m_new, j_new, ks_byte;

	logic in_fire;
	assign in_fire   = in_valid && in_ready;
	assign in_ready  = (state_q == rc4sc_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= rc4sc_pkg::KEY_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			key_length_q <= cfg_data;
		end
	end

	always_comb begin
		if (key_length_q == 9'd0) begin
			n_eff = 9'd1;
		end else if (key_length_q > 9'(MAX_KEY_BYTES)) begin
			n_eff = 9'(MAX_KEY_BYTES);
		end else begin
			n_eff = key_length_q;
		end
	end

	assign kk_last = (9'(kk_q) == (n_eff - 9'd1));

	// key memory
	always_ff @(posedge clk) begin
		if (in_fire && in_req.command == rc4sc_pkg::CMD_LOAD
				&& 9'(in_req.key_index) < 9'(MAX_KEY_BYTES)) begin
			key_mem[in_req.key_index[KW-1:0]] <= in_req.key_byte;
		end
	end

	always_ff @(posedge clk) begin
		key_rd_q <= key_mem[kk_q];
	end

	rc4sc_sbox_ram u_sbox (
		.clk   (clk),
		.req   (sbox_req),
		.rdata (s_rdata)
	);

	// schedule: take S[k] from the last write when it hit k
	assign ks_a    = fwd_q ? a_q : s_rdata;
	assign m_new   = m_q + ks_a + key_rd_q;
	assign j_new   = j_q + s_rdata;
	// keystream read raced the swap writes: take the newest value
	assign ks_byte = (t_q == j_q) ? a_q : ((t_q == i_q) ? b_q : s_rdata);

	always_comb begin
		state_d        = state_q;
		sbox_req.we    = 1'b0;
		sbox_req.waddr = k_q;
		sbox_req.wdata = k_q;
		sbox_req.raddr = i_q + 8'd1;
		res_valid      = 1'b0;
		res            = '0;
		case (state_q)
			rc4sc_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (in_req.command)
						rc4sc_pkg::CMD_LOAD: begin
							res_valid    = 1'b1;
							res.out_kind = rc4sc_pkg::KIND_KEY;
						end
						rc4sc_pkg::CMD_SCHED: state_d = rc4sc_pkg::ST_INIT;
						rc4sc_pkg::CMD_CRYPT: state_d = rc4sc_pkg::ST_CR_A;
						default: state_d = rc4sc_pkg::ST_IDLE;
					endcase
				end
			end
			rc4sc_pkg::ST_INIT: begin
				sbox_req.we    = 1'b1;
				sbox_req.raddr = '0;
				if (k_q == 8'hFF) begin
					state_d = rc4sc_pkg::ST_KS_A;
				end
			end
			rc4sc_pkg::ST_KS_A: begin
				sbox_req.raddr = m_new;
				state_d        = rc4sc_pkg::ST_KS_B;
			end
			rc4sc_pkg::ST_KS_B: begin
				sbox_req.we    = 1'b1;
				sbox_req.wdata = s_rdata;
				state_d        = rc4sc_pkg::ST_KS_C;
			end
			rc4sc_pkg::ST_KS_C: begin
				sbox_req.we    = 1'b1;
				sbox_req.waddr = m_q;
				sbox_req.wdata = a_q;
				sbox_req.raddr = k_q + 8'd1;
				if (k_q == 8'hFF) begin
					res_valid    = 1'b1;
					res.out_kind = rc4sc_pkg::KIND_SCHED;
				end else begin
					state_d = rc4sc_pkg::ST_KS_A;
				end
			end
			rc4sc_pkg::ST_CR_A: begin
				sbox_req.raddr = j_new;
				state_d        = rc4sc_pkg::ST_CR_B;
			end
			rc4sc_pkg::ST_CR_B: begin
				sbox_req.we    = 1'b1;
				sbox_req.waddr = i_q;
				sbox_req.wdata = s_rdata;
				sbox_req.raddr = a_q + s_rdata;
				state_d        = rc4sc_pkg::ST_CR_C;
			end
			rc4sc_pkg::ST_CR_C: begin
				sbox_req.we    = 1'b1;
				sbox_req.waddr = j_q;
				sbox_req.wdata = a_q;
				res_valid      = 1'b1;
				res.out_kind   = rc4sc_pkg::KIND_CRYPT;
				res.out_byte   = data_q ^ ks_byte;
				res.out_last   = last_q;
			end
			rc4sc_pkg::ST_PUSH: begin
				res_valid = 1'b1;
				res       = res_q;
			end
			default: state_d = rc4sc_pkg::ST_IDLE;
		endcase
		// park the result when the output register is still full
		if (res_valid) begin
			state_d = slot_free ? rc4sc_pkg::ST_IDLE : rc4sc_pkg::ST_PUSH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rc4sc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// indices and schedule control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			j_q   <= '0;
			k_q   <= '0;
			m_q   <= '0;
			kk_q  <= '0;
			fwd_q <= 1'b0;
		end else begin
			case (state_q)
				rc4sc_pkg::ST_IDLE: begin
					if (in_fire && in_req.command == rc4sc_pkg::CMD_CRYPT) begin
						i_q <= i_q + 8'd1;
					end
					k_q  <= '0;
					kk_q <= '0;
				end
				rc4sc_pkg::ST_INIT: begin
					k_q   <= k_q + 8'd1;
					m_q   <= '0;
					fwd_q <= 1'b0;
				end
				rc4sc_pkg::ST_KS_A: begin
					m_q  <= m_new;
					kk_q <= kk_last ? '0 : kk_q + KW'(1);
				end
				rc4sc_pkg::ST_KS_C: begin
					fwd_q <= (m_q == k_q + 8'd1);
					k_q   <= k_q + 8'd1;
					if (k_q == 8'hFF) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				rc4sc_pkg::ST_CR_A: begin
					j_q <= j_new;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_q <= in_req.data_byte;
			last_q <= in_req.last_byte;
		end
		if (state_q == rc4sc_pkg::ST_KS_A) begin
			a_q <= ks_a;
		end
		if (state_q == rc4sc_pkg::ST_CR_A) begin
			a_q <= s_rdata;
		end
		if (state_q == rc4sc_pkg::ST_CR_B) begin
			b_q <= s_rdata;
			t_q <= a_q + s_rdata;
		end
		if (res_valid && state_q != rc4sc_pkg::ST_PUSH) begin
			res_q <= res;
		end
		if (res_valid && slot_free) begin
			out_q <= res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;

`ifndef SYNTHESIS
	a_crypt_steps: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_req.command == rc4sc_pkg::CMD_CRYPT
		|=> state_q == rc4sc_pkg::ST_CR_A ##1 state_q == rc4sc_pkg::ST_CR_B
		##1 state_q == rc4sc_pkg::ST_CR_C)
		else $error("crypt request left the three step sequence");

	a_key_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rc4sc_pkg::ST_KS_A |-> 9'(kk_q) < n_eff)
		else $error("key index beyond effective key length");

	a_quiet_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rsp.out_kind != rc4sc_pkg::KIND_CRYPT
		|-> out_rsp.out_byte == 8'd0 && !out_rsp.out_last)
		else $error("non-crypt result carries data");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		sbox_req.we |-> state_q == rc4sc_pkg::ST_INIT || state_q == rc4sc_pkg::ST_KS_B
		|| state_q == rc4sc_pkg::ST_KS_C || state_q == rc4sc_pkg::ST_CR_B
		|| state_q == rc4sc_pkg::ST_CR_C)
		else $error("permutation write outside a write step");
`endif

endmodule

### bench/rc4_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_checker
// Watches the request, result and key length channels of the RC4 block. It
// keeps its own permutation, key store and indices, works out the result
// of every accepted request, and compares each accepted result with the
// oldest one still due.
// ----------------------------------------------------------------------------
module rc4_checker
	import rc4sc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  req_t        in_req,
	input  logic        out_valid,
	input  logic        out_ready,
	input  rsp_t        out_rsp,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [8:0]  cfg_data,
	output int unsigned mismatch_count,
	output int unsigned due_count
);

	localparam int unsigned KEY_SLOTS = 256;
	localparam int unsigned SHOWN_ERRORS = 10;

	logic [7:0]  sbox [SBOX_DEPTH];
	logic [7:0]  key_mem [KEY_SLOTS];
	logic [7:0]  step_idx;
	logic [7:0]  mix_idx;
	logic [8:0]  key_len;
	rsp_t        results_due [$];
	int unsigned errors;

	task automatic flag(input string msg);
		errors++;
		if (errors <= SHOWN_ERRORS) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	task automatic run_key_schedule();
		int unsigned n;
		logic [7:0]  a;
		logic [7:0]  m;
		n = key_len;
		if (n == 0) begin
			n = 1;
		end
		if (n > KEY_SLOTS) begin
			n = KEY_SLOTS;
		end
		for (int k = 0; k < SBOX_DEPTH; k++) begin
			sbox[k] = 8'(k);
		end
		m = '0;
		for (int k = 0; k < SBOX_DEPTH; k++) begin
			a = sbox[k];
			m = m + a + key_mem[k % n];
			sbox[k] = sbox[m];
			sbox[m] = a;
		end
		step_idx = '0;
		mix_idx  = '0;
	endtask

	task automatic predict_request(input req_t r);
		rsp_t       want;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] ks_idx;
		want = '0;
		case (r.command)
			CMD_LOAD: begin
				key_mem[r.key_index] = r.key_byte;
				want.out_kind = KIND_KEY;
				results_due.push_back(want);
			end
			CMD_SCHED: begin
				run_key_schedule();
				want.out_kind = KIND_SCHED;
				results_due.push_back(want);
			end
			CMD_CRYPT: begin
				step_idx = step_idx + 8'd1;
				a = sbox[step_idx];
				mix_idx = mix_idx + a;
				b = sbox[mix_idx];
				sbox[step_idx] = b;
				sbox[mix_idx] = a;
				ks_idx = a + b;
				want.out_kind = KIND_CRYPT;
				want.out_byte = r.data_byte ^ sbox[ks_idx];
				want.out_last = r.last_byte;
				results_due.push_back(want);
			end
			default: begin
				// unused command: no state change, no result
			end
		endcase
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (results_due.size() == 0) begin
			flag($sformatf("result with nothing due: kind %0d byte %02h last %0d",
				got.out_kind, got.out_byte, got.out_last));
		end else begin
			want = results_due.pop_front();
			if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
					got.out_last !== want.out_last) begin
				flag($sformatf({"result mismatch: expected kind %0d byte %02h last %0d,",
					" got kind %0d byte %02h last %0d"},
					want.out_kind, want.out_byte, want.out_last,
					got.out_kind, got.out_byte, got.out_last));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_idx = '0;
			mix_idx  = '0;
			key_len  = KEY_LENGTH_RESET;
			errors   = 0;
			results_due.delete();
			mismatch_count <= 0;
			due_count      <= 0;
		end else begin
			// drain first so a result never meets its own request
			if (out_valid && out_ready) begin
				check_result(out_rsp);
			end
			if (in_valid && in_ready) begin
				predict_request(in_req);
			end
			if (cfg_valid && cfg_ready) begin
				key_len = cfg_data;
			end
			mismatch_count <= errors;
			due_count      <= results_due.size();
		end
	end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the RC4 block with key loads, key schedules and crypt messages under
// a series of key lengths, with random idle bursts on both channels, and
// reports the verdict from the checker's error count and count of results still due.
// ----------------------------------------------------------------------------
module tb;
	import rc4sc_pkg::*;

	localparam int          CLK_PERIOD  = 12;
	localparam int          SETTLE      = 24;
	localparam int unsigned CYCLE_LIMIT = 900_000;
	localparam int unsigned ITEM_TARGET = 1500;
	localparam int          NUM_PHASES  = 7;
	localparam int unsigned KEY_SLOTS   = 256;
	localparam logic [1:0]  CMD_UNUSED  = 2'd3;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	req_t        in_req    = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	rsp_t        out_rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [8:0]  cfg_data  = '0;
	int unsigned mismatch_count;
	int unsigned due_count;

	bit          calm      = 1'b0;
	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;
	int unsigned items_sent = 0;
	int unsigned cur_key_len = KEY_LENGTH_RESET;
	bit          key_written [KEY_SLOTS];
	bit          scheduled = 1'b0;

	rc4_stream_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	rc4_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_req         (in_req),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_rsp        (out_rsp),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.due_count      (due_count)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// result side: random stall bursts unless the run has gone calm
	initial begin
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic int unsigned eff_len(input int unsigned v);
		if (v == 0) begin
			return 1;
		end
		if (v > KEY_SLOTS) begin
			return KEY_SLOTS;
		end
		return v;
	endfunction

	function automatic req_t make_req(input logic [1:0] cmd);
		req_t r;
		r.command   = cmd;
		r.key_index = 8'($urandom);
		r.key_byte  = 8'($urandom);
		r.data_byte = 8'($urandom);
		r.last_byte = 1'($urandom);
		return r;
	endfunction

	task automatic push_request(input req_t r);
		in_req   <= r;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (r.command != CMD_UNUSED) begin
			items_sent++;
		end
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic load_key(input logic [7:0] idx, input logic [7:0] val);
		req_t r;
		r = make_req(CMD_LOAD);
		r.key_index = idx;
		r.key_byte  = val;
		push_request(r);
		key_written[idx] = 1'b1;
	endtask

	task automatic crypt_byte(input logic [7:0] val, input logic last);
		req_t r;
		r = make_req(CMD_CRYPT);
		r.data_byte = val;
		r.last_byte = last;
		push_request(r);
	endtask

	// fill every key byte the schedule will read, refresh some, then schedule
	task automatic rekey();
		int unsigned n;
		n = eff_len(cur_key_len);
		for (int k = 0; k < n; k++) begin
			if (!key_written[k] || $urandom_range(0, 3) == 0) begin
				load_key(8'(k), 8'($urandom));
			end
		end
		repeat ($urandom_range(0, 3)) load_key(8'($urandom), 8'($urandom));
		push_request(make_req(CMD_SCHED));
		scheduled = 1'b1;
	endtask

	task automatic send_message();
		int unsigned len;
		len = ($urandom_range(0, 11) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
		for (int unsigned b = 0; b < len; b++) begin
			if ($urandom_range(0, 24) == 0) begin
				push_request(make_req(CMD_UNUSED));
			end
			if ($urandom_range(0, 29) == 0) begin
				load_key(8'($urandom), 8'($urandom));
			end
			crypt_byte(8'($urandom), (b == len - 1) || ($urandom_range(0, 15) == 0));
		end
	endtask

	// hold the sender until every result is back, then let the block settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_key_length(input logic [8:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_key_len = v;
	endtask

	initial begin
		int unsigned phase_len [NUM_PHASES];
		int unsigned budget;
		req_t        r;

		phase_len = '{16, 1, 256, 0, 511, 300, 0};
		phase_len[NUM_PHASES - 1] = $urandom_range(2, 255);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme key bytes, unused command, extreme data bytes
		gap_pct   = 20;
		stall_pct = 20;
		for (int k = 0; k < 16; k++) begin
			load_key(8'(k), (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom));
		end
		load_key(8'hFF, 8'hFF);
		r = '1;
		r.command = CMD_UNUSED;
		push_request(r);
		push_request(make_req(CMD_SCHED));
		scheduled = 1'b1;
		crypt_byte(8'h00, 1'b0);
		crypt_byte(8'hFF, 1'b0);
		crypt_byte(8'h00, 1'b1);
		crypt_byte(8'hFF, 1'b1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				wait_drained();
				write_key_length(9'(phase_len[p]));
			end
			calm      = (p == NUM_PHASES - 1);
			gap_pct   = (p == 1) ? 0 : $urandom_range(10, 50);
			stall_pct = (p == 1) ? 0 : $urandom_range(10, 50);
			budget = items_sent + ITEM_TARGET / NUM_PHASES;
			if (p > 0) begin
				rekey();
			end
			while (items_sent < budget) begin
				if (!scheduled || $urandom_range(0, 9) == 0) begin
					rekey();
				end
				send_message();
			end
		end

		wait_drained();
		if (mismatch_count == 0 && due_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
